### rtl/core/window_pixel_address_counter_core_assert.svh
// Assertion macros for the window pixel address counter checker.
// Assumes clk and rst_n are in scope where the macros are used.
`ifndef WINDOW_PIXEL_ADDRESS_COUNTER_CORE_ASSERT_SVH
`define WINDOW_PIXEL_ADDRESS_COUNTER_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define WPAC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define WPAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds through reset
`define WPAC_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/wpac_pkg.sv
// Shared types and constants for the window pixel address counter.
// No dependencies; used by wpac_cursor and the top level.
`default_nettype none

package wpac_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;
  localparam int WIN_W      = 7;
  localparam int COLOR_IN_W = 16;
  localparam int ADDR_OUT_W = 14;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIN_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_RIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_BOTTOM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIRROR_X   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIRROR_Y   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SWAP_AXES  = 3'd6;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef struct packed {
    logic                  operation;
    logic                  restart;
    logic [COLOR_IN_W-1:0] pixel_color;
    logic                  burst_end;
  } in_item_t;

  typedef struct packed {
    logic [COLOR_IN_W-1:0] read_color;
    logic [ADDR_OUT_W-1:0] pixel_address;
    logic                  window_rejected;
    logic                  burst_done;
  } out_item_t;

  // per-transaction status from the cursor unit
  typedef struct packed {
    logic rejected;
    logic in_range;
  } acc_info_t;

endpackage

`default_nettype wire

### rtl/core/wpac_cursor.sv
// Window registers, latched physical window and cursor with its advance logic.
// Depends on wpac_pkg.
`default_nettype none

module wpac_cursor #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 128,
  parameter int ADDR_W        = 14
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               cfg_we,
  input  wire  [wpac_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [wpac_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire                               acc,
  input  wire                               restart,
  output wpac_pkg::acc_info_t               info,
  output logic [ADDR_W-1:0]                 addr
);

  localparam int COL_MAX   = (SCREEN_WIDTH - 1 > 127) ? SCREEN_WIDTH - 1 : 127;
  localparam int ROW_MAX   = (SCREEN_HEIGHT - 1 > 127) ? SCREEN_HEIGHT - 1 : 127;
  localparam int COL_W     = $clog2(COL_MAX + 1);
  localparam int ROW_W     = $clog2(ROW_MAX + 1);
  localparam int CRD_W     = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int STORE_SIZE = SCREEN_WIDTH * SCREEN_HEIGHT;

  typedef struct packed {
    logic             wrap;
    logic [CRD_W-1:0] pos;
  } step_t;

  function automatic step_t axis_step(input logic [CRD_W-1:0] pos,
                                      input logic [CRD_W-1:0] lo,
                                      input logic [CRD_W-1:0] hi,
                                      input logic             rev);
    step_t s;
    s.wrap = 1'b0;
    if (!rev) begin
      if (pos >= hi) begin
        s.pos  = lo;
        s.wrap = 1'b1;
      end else begin
        s.pos = CRD_W'(pos + 1'b1);
      end
    end else begin
      if (pos <= lo) begin
        s.pos  = hi;
        s.wrap = 1'b1;
      end else begin
        s.pos = CRD_W'(pos - 1'b1);
      end
    end
    return s;
  endfunction

  logic [wpac_pkg::WIN_W-1:0] win_left_r, win_right_r, win_top_r, win_bottom_r;
  logic                       mirror_x_r, mirror_y_r, swap_axes_r;

  logic [COL_W-1:0] phys_left_r, phys_right_r, col_r;
  logic [ROW_W-1:0] phys_top_r, phys_bottom_r, row_r;
  logic [COL_W-1:0] phys_left_nxt, phys_right_nxt, col_nxt, col_e;
  logic [ROW_W-1:0] phys_top_nxt, phys_bottom_nxt, row_nxt, row_e;

  logic             win_ok, latch;
  logic [ADDR_W-1:0] addr_full;
  step_t            col_step, row_step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_left_r   <= '0;
      win_right_r  <= 7'd127;
      win_top_r    <= '0;
      win_bottom_r <= 7'd127;
      mirror_x_r   <= 1'b0;
      mirror_y_r   <= 1'b0;
      swap_axes_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        wpac_pkg::REG_WIN_LEFT:   win_left_r   <= cfg_wdata;
        wpac_pkg::REG_WIN_RIGHT:  win_right_r  <= cfg_wdata;
        wpac_pkg::REG_WIN_TOP:    win_top_r    <= cfg_wdata;
        wpac_pkg::REG_WIN_BOTTOM: win_bottom_r <= cfg_wdata;
        wpac_pkg::REG_MIRROR_X:   mirror_x_r   <= cfg_wdata[0];
        wpac_pkg::REG_MIRROR_Y:   mirror_y_r   <= cfg_wdata[0];
        wpac_pkg::REG_SWAP_AXES:  swap_axes_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    win_ok = (32'(win_left_r) < SCREEN_WIDTH) && (32'(win_right_r) < SCREEN_WIDTH) &&
             (32'(win_top_r) < SCREEN_HEIGHT) && (32'(win_bottom_r) < SCREEN_HEIGHT);
    latch  = restart && win_ok;

    phys_left_nxt   = phys_left_r;
    phys_right_nxt  = phys_right_r;
    phys_top_nxt    = phys_top_r;
    phys_bottom_nxt = phys_bottom_r;
    if (latch) begin
      if (swap_axes_r) begin
        phys_top_nxt    = ROW_W'(win_left_r);
        phys_bottom_nxt = ROW_W'(win_right_r);
        phys_left_nxt   = COL_W'(win_top_r);
        phys_right_nxt  = COL_W'(win_bottom_r);
      end else begin
        phys_left_nxt   = COL_W'(win_left_r);
        phys_right_nxt  = COL_W'(win_right_r);
        phys_top_nxt    = ROW_W'(win_top_r);
        phys_bottom_nxt = ROW_W'(win_bottom_r);
      end
    end

    // start corner follows each axis's own mirror
    if (latch) begin
      row_e = mirror_y_r ? phys_bottom_nxt : phys_top_nxt;
      col_e = mirror_x_r ? phys_right_nxt : phys_left_nxt;
    end else begin
      row_e = row_r;
      col_e = col_r;
    end

    addr_full = ADDR_W'(row_e) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(col_e);

    col_step = axis_step(CRD_W'(col_e), CRD_W'(phys_left_nxt), CRD_W'(phys_right_nxt),
                         mirror_x_r);
    row_step = axis_step(CRD_W'(row_e), CRD_W'(phys_top_nxt), CRD_W'(phys_bottom_nxt),
                         mirror_y_r);

    if (swap_axes_r) begin
      row_nxt = ROW_W'(row_step.pos);
      col_nxt = row_step.wrap ? COL_W'(col_step.pos) : col_e;
    end else begin
      col_nxt = COL_W'(col_step.pos);
      row_nxt = col_step.wrap ? ROW_W'(row_step.pos) : row_e;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phys_left_r   <= '0;
      phys_right_r  <= COL_W'(SCREEN_WIDTH - 1);
      phys_top_r    <= '0;
      phys_bottom_r <= ROW_W'(SCREEN_HEIGHT - 1);
      col_r         <= '0;
      row_r         <= '0;
    end else if (acc) begin
      phys_left_r   <= phys_left_nxt;
      phys_right_r  <= phys_right_nxt;
      phys_top_r    <= phys_top_nxt;
      phys_bottom_r <= phys_bottom_nxt;
      col_r         <= col_nxt;
      row_r         <= row_nxt;
    end
  end

  assign addr          = addr_full;
  assign info.rejected = restart && !win_ok;
  assign info.in_range = 32'(addr_full) < STORE_SIZE;

endmodule

`default_nettype wire

### rtl/core/wpac_store.sv
// Pixel frame store: single-port synchronous RAM with a zeroing sweep after reset.
// Depends on wpac_pkg only through the instantiating top level.
`default_nettype none

module wpac_store #(
  parameter int DEPTH  = 16384,
  parameter int DATA_W = 16
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          re,
  input  wire                          we,
  input  wire  [$clog2(DEPTH)-1:0]     addr,
  input  wire  [DATA_W-1:0]            wdata,
  output logic [DATA_W-1:0]            rdata,
  output logic                         busy
);

  localparam int IDX_W = $clog2(DEPTH);

  logic [DATA_W-1:0] store_mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;
  logic              clr_busy_r, clr_busy_nxt;
  logic [IDX_W-1:0]  clr_idx_r, clr_idx_nxt;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [DATA_W-1:0] mem_wdata;

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_idx_nxt  = clr_idx_r;
    if (clr_busy_r) begin
      clr_idx_nxt = IDX_W'(clr_idx_r + 1'b1);
      if (clr_idx_r == IDX_W'(DEPTH - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
    mem_we    = clr_busy_r || we;
    mem_waddr = clr_busy_r ? clr_idx_r : addr;
    mem_wdata = clr_busy_r ? '0 : wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_idx_r  <= clr_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= store_mem[addr];
    end
  end

  assign rdata = rdata_r;
  assign busy  = clr_busy_r;

endmodule

`default_nettype wire

### rtl/core/window_pixel_address_counter_core.sv
// Window pixel address counter top level: cursor unit, frame store, result pipeline.
// Depends on wpac_pkg, wpac_cursor and wpac_store.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall   wpac_pkg::in_item_t
//   out_     output     out_valid / out_stall wpac_pkg::out_item_t
//   cfg_     input      cfg_we                cfg_index, cfg_wdata
//
// One transaction per cycle while in_stall is low; each result passes through
// the store access on accept, the registered read data, then the output register.
// After reset the store is zeroed one entry per cycle, all SCREEN_WIDTH *
// SCREEN_HEIGHT entries (16384 at defaults), with in_stall held high.
// Back-pressure on out_ reaches in_stall in the same cycle once the
// single middle stage is occupied.
`default_nettype none

module window_pixel_address_counter_core #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 128,
  parameter int PIXEL_BITS    = 16
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  wpac_pkg::in_item_t         in_data,
  output logic                             out_valid,
  input  wire                              out_stall,
  output wpac_pkg::out_item_t              out_data,
  input  wire                              cfg_we,
  input  wire  [wpac_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [wpac_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int COL_MAX    = (SCREEN_WIDTH - 1 > 127) ? SCREEN_WIDTH - 1 : 127;
  localparam int ROW_MAX    = (SCREEN_HEIGHT - 1 > 127) ? SCREEN_HEIGHT - 1 : 127;
  localparam int ADDR_W     = $clog2(ROW_MAX * SCREEN_WIDTH + COL_MAX + 1);
  localparam int STORE_SIZE = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int IDX_W      = $clog2(STORE_SIZE);

  logic                acc;
  logic                is_read;
  wpac_pkg::acc_info_t info;
  logic [ADDR_W-1:0]   addr;
  logic                st_busy;
  logic [PIXEL_BITS-1:0] st_rdata, st_wdata;
  logic [31:0]         wr_ext, rd_ext;

  // middle stage: store access in flight
  logic                s1_valid_r, s1_valid_nxt;
  logic                s1_rd_r, s1_rej_r, s1_last_r;
  logic [wpac_pkg::ADDR_OUT_W-1:0] s1_addr_r;
  logic                s1_move;

  logic                out_valid_r, out_valid_nxt;
  wpac_pkg::out_item_t out_r, out_nxt;

  assign is_read = (in_data.operation == wpac_pkg::OP_READ);
  assign s1_move = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = st_busy || (s1_valid_r && !s1_move);
  assign acc     = in_valid && !in_stall;

  assign wr_ext   = 32'(in_data.pixel_color);
  assign st_wdata = wr_ext[PIXEL_BITS-1:0];
  assign rd_ext   = 32'(st_rdata);

  wpac_cursor #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .ADDR_W        (ADDR_W)
  ) u_cursor (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .acc       (acc),
    .restart   (in_data.restart),
    .info      (info),
    .addr      (addr)
  );

  wpac_store #(
    .DEPTH  (STORE_SIZE),
    .DATA_W (PIXEL_BITS)
  ) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .re    (acc && is_read && info.in_range),
    .we    (acc && !is_read && info.in_range),
    .addr  (IDX_W'(addr)),
    .wdata (st_wdata),
    .rdata (st_rdata),
    .busy  (st_busy)
  );

  always_comb begin
    s1_valid_nxt  = acc || (s1_valid_r && !s1_move);
    out_valid_nxt = s1_move || (out_valid_r && out_stall);
    out_nxt       = out_r;
    if (s1_move) begin
      out_nxt.read_color      = s1_rd_r ? rd_ext[wpac_pkg::COLOR_IN_W-1:0] : '0;
      out_nxt.pixel_address   = s1_addr_r;
      out_nxt.window_rejected = s1_rej_r;
      out_nxt.burst_done      = s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_rd_r   <= is_read && info.in_range;
      s1_rej_r  <= info.rejected;
      s1_last_r <= in_data.burst_end;
      s1_addr_r <= wpac_pkg::ADDR_OUT_W'(addr);
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

### rtl/core/wpac_chk.sv
// Port-level checker for window_pixel_address_counter_core, bound to the top.
// Depends on window_pixel_address_counter_core_assert.svh.
`default_nettype none

`include "window_pixel_address_counter_core_assert.svh"

module wpac_chk (
  input wire clk,
  input wire rst_n,
  input wire in_valid,
  input wire in_stall,
  input wire out_valid,
  input wire out_stall
);

  // a stalled result stays offered
  `WPAC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

  // a result rising on an empty output stage came from a transaction that passed straight through the middle stage
  `WPAC_ASSERT_IMPL(a_out_origin, $rose(out_valid), $past(in_valid && !in_stall, 2), "result without matching input")

  // store zeroing keeps the input closed after reset
  `WPAC_ASSERT_RST(a_clear_stall, !rst_n, in_stall, "input open during store clear")

endmodule

bind window_pixel_address_counter_core wpac_chk u_wpac_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall)
);

`default_nettype wire
